// ===== design/bmhpq_pkg.sv =====
// Shared types, codes and constants of the binary max-heap priority queue.
`default_nettype none

package bmhpq_pkg;

    // Default number of heap slots
    localparam int CAPACITY_DEF = 64;

    // Field widths
    localparam int KEY_W  = 32;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PEEK   = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    // Request payload
    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [KEY_W-1:0] key;
    } req_t;

    // Result payload
    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [KEY_W-1:0] result_key;
        logic [CNT_W-1:0]        element_count;
    } rsp_t;

    // Finished result handed from the controller to the output stage
    typedef struct packed {
        logic load;
        rsp_t rsp;
    } rsp_load_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ROOT_RD,
        S_ROOT_WAIT,
        S_LAST_RD,
        S_LAST_WAIT,
        S_SCAN,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_UP_RD,
        S_UP_CMP,
        S_FINAL_WR,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== design/binary_max_heap_priority_queue.sv =====
// Top level of the bounded binary max-heap priority queue.
//
// Request channel s_valid/s_ready/s_req carries a mode (insert, pop, remove,
// peek) and a signed 32-bit key. Result channel m_valid/m_ready/m_rsp gives
// one result per request: status, key and the element count afterwards.
// Requests are handled one at a time; the heap lives in a single RAM with a
// registered read, so each sift level costs memory round trips:
//   insert      : climbs L levels, with a last compare and no swap when the key
//                 stops below the root (L at most log2(CAPACITY))
//   pop         : root read, last-slot read, then L levels descended; the
//                 last-slot read ends it when it takes the only key
//   peek        : root read only
//   remove      : scan at one slot a cycle (a miss ends the scan with not found),
//                 then as pop less the root read, plus a climb of levels when the
//                 moved key climbs
//   full/empty  : answered without a memory access
// A new request is taken while the previous result still sits in the output
// register; a result waits in the controller only if that register is full.
// A stalled receiver holds m_rsp steady and eventually blocks new requests.
// Reset (aresetn low, synchronous) empties the heap and drops any held result;
// RAM contents are left as they are since only slots below the count are read.
`default_nettype none

module binary_max_heap_priority_queue #(
    parameter int CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire bmhpq_pkg::req_t s_req,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output bmhpq_pkg::rsp_t      m_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int KW = bmhpq_pkg::KEY_W;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [KW-1:0]        rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [KW-1:0]        wr_data;
    logic                 out_free;
    bmhpq_pkg::rsp_load_t rsp_ld;

    // Heap slot storage
    bmhpq_ram #(
        .WIDTH  (KW),
        .DEPTH  (CAPACITY),
        .ADDR_W (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Request sequencer
    bmhpq_ctrl #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (AW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_req    (s_req),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .out_free (out_free),
        .rsp_ld   (rsp_ld)
    );

    // Result register
    bmhpq_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rsp_ld   (rsp_ld),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_rsp    (m_rsp)
    );

endmodule

`default_nettype wire

// ===== design/bmhpq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module bmhpq_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/bmhpq_ctrl.sv =====
// Heap controller: sequences slot reads, compares and write-backs for each request.
`default_nettype none

module bmhpq_ctrl #(
    parameter int CAPACITY = bmhpq_pkg::CAPACITY_DEF,
    parameter int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // request channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire bmhpq_pkg::req_t                   s_req,
    // heap memory
    output logic                                   rd_en,
    output logic [ADDR_W-1:0]                      rd_addr,
    input  wire logic [bmhpq_pkg::KEY_W-1:0]       rd_data,
    output logic                                   wr_en,
    output logic [ADDR_W-1:0]                      wr_addr,
    output logic [bmhpq_pkg::KEY_W-1:0]            wr_data,
    // output stage
    input  wire logic                              out_free,
    output bmhpq_pkg::rsp_load_t                   rsp_ld
);

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int IW     = ADDR_W + 2;
    localparam int KW     = bmhpq_pkg::KEY_W;
    localparam int CNT_OW = bmhpq_pkg::CNT_W;

    bmhpq_pkg::state_t state_reg, state_next;

    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [CW-1:0]              scan_idx_reg, scan_idx_next;
    logic                       chk_vld_reg, chk_vld_next;
    logic [ADDR_W-1:0]          chk_idx_reg, chk_idx_next;
    logic [ADDR_W-1:0]          pos_reg, pos_next;
    logic                       moved_reg, moved_next;
    logic                       has_r_reg, has_r_next;
    logic [bmhpq_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic signed [KW-1:0]       key_reg, key_next;
    logic signed [KW-1:0]       mov_reg, mov_next;
    logic signed [KW-1:0]       lval_reg, lval_next;
    logic signed [KW-1:0]       rkey_reg, rkey_next;
    logic [bmhpq_pkg::STAT_W-1:0] status_reg, status_next;

    logic                       accept;
    logic signed [KW-1:0]       rd_key;
    logic [CW-1:0]              cnt_m1;
    logic [IW-1:0]              cnt_ext;
    logic [IW-1:0]              left_idx;
    logic [IW-1:0]              right_idx;
    logic                       has_left;
    logic                       has_right;
    logic [ADDR_W-1:0]          parent_idx;
    logic                       is_full;
    logic                       is_empty;
    logic                       scan_more;
    logic                       scan_hit;
    logic                       pos_live;
    logic                       left_wins;
    logic signed [KW-1:0]       cand_val;
    logic                       right_wins;
    logic                       dn_stop;
    logic signed [KW-1:0]       big_val;
    logic [ADDR_W-1:0]          big_idx;
    logic                       up_swap;

    // Shared index arithmetic and compares
    assign accept     = s_valid && s_ready;
    assign rd_key     = $signed(rd_data);
    assign cnt_m1     = cnt_reg - CW'(1);
    assign cnt_ext    = IW'(cnt_reg);
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + IW'(1);
    assign has_left   = left_idx < cnt_ext;
    assign has_right  = right_idx < cnt_ext;
    assign parent_idx = (pos_reg - ADDR_W'(1)) >> 1;
    assign is_full    = cnt_reg == CW'(CAPACITY);
    assign is_empty   = cnt_reg == '0;
    assign scan_more  = scan_idx_reg < cnt_reg;
    assign scan_hit   = chk_vld_reg && (rd_key == key_reg);
    assign pos_live   = CW'(pos_reg) < cnt_reg;

    // Pick the largest of the hole key and its children
    assign left_wins  = mov_reg < lval_reg;
    assign cand_val   = left_wins ? lval_reg : mov_reg;
    assign right_wins = has_r_reg && (cand_val < rd_key);
    assign dn_stop    = !left_wins && !right_wins;
    assign big_val    = right_wins ? rd_key : lval_reg;
    assign big_idx    = right_wins ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
    assign up_swap    = rd_key < mov_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bmhpq_pkg::S_IDLE: begin
                if (accept) begin
                    case (s_req.mode)
                        bmhpq_pkg::MODE_INSERT: begin
                            state_next = is_full ? bmhpq_pkg::S_DONE : bmhpq_pkg::S_UP_RD;
                        end
                        bmhpq_pkg::MODE_REMOVE: begin
                            state_next = is_empty ? bmhpq_pkg::S_DONE : bmhpq_pkg::S_SCAN;
                        end
                        default: begin
                            state_next = is_empty ? bmhpq_pkg::S_DONE : bmhpq_pkg::S_ROOT_RD;
                        end
                    endcase
                end
            end
            bmhpq_pkg::S_ROOT_RD: begin
                state_next = bmhpq_pkg::S_ROOT_WAIT;
            end
            bmhpq_pkg::S_ROOT_WAIT: begin
                state_next = (mode_reg == bmhpq_pkg::MODE_PEEK) ? bmhpq_pkg::S_DONE
                                                                 : bmhpq_pkg::S_LAST_RD;
            end
            bmhpq_pkg::S_SCAN: begin
                if (scan_hit) begin
                    state_next = bmhpq_pkg::S_LAST_RD;
                end else if (!scan_more) begin
                    state_next = bmhpq_pkg::S_DONE;
                end
            end
            bmhpq_pkg::S_LAST_RD: begin
                state_next = bmhpq_pkg::S_LAST_WAIT;
            end
            bmhpq_pkg::S_LAST_WAIT: begin
                state_next = pos_live ? bmhpq_pkg::S_DN_RDL : bmhpq_pkg::S_DONE;
            end
            bmhpq_pkg::S_DN_RDL: begin
                if (has_left) begin
                    state_next = bmhpq_pkg::S_DN_RDR;
                end else begin
                    state_next = moved_reg ? bmhpq_pkg::S_FINAL_WR : bmhpq_pkg::S_UP_RD;
                end
            end
            bmhpq_pkg::S_DN_RDR: begin
                state_next = bmhpq_pkg::S_DN_CMP;
            end
            bmhpq_pkg::S_DN_CMP: begin
                if (dn_stop) begin
                    state_next = moved_reg ? bmhpq_pkg::S_FINAL_WR : bmhpq_pkg::S_UP_RD;
                end else begin
                    state_next = bmhpq_pkg::S_DN_RDL;
                end
            end
            bmhpq_pkg::S_UP_RD: begin
                state_next = (pos_reg == '0) ? bmhpq_pkg::S_FINAL_WR : bmhpq_pkg::S_UP_CMP;
            end
            bmhpq_pkg::S_UP_CMP: begin
                state_next = up_swap ? bmhpq_pkg::S_UP_RD : bmhpq_pkg::S_FINAL_WR;
            end
            bmhpq_pkg::S_FINAL_WR: begin
                state_next = bmhpq_pkg::S_DONE;
            end
            bmhpq_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = bmhpq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bmhpq_pkg::S_IDLE;
            end
        endcase
    end

    // Memory strobes, handshake and result hand-off
    always_comb begin
        s_ready = 1'b0;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = mov_reg;
        case (state_reg)
            bmhpq_pkg::S_IDLE: begin
                s_ready = 1'b1;
            end
            bmhpq_pkg::S_ROOT_RD: begin
                rd_en = 1'b1;
            end
            bmhpq_pkg::S_SCAN: begin
                rd_en   = scan_more;
                rd_addr = scan_idx_reg[ADDR_W-1:0];
            end
            bmhpq_pkg::S_LAST_RD: begin
                rd_en   = 1'b1;
                rd_addr = cnt_m1[ADDR_W-1:0];
            end
            bmhpq_pkg::S_DN_RDL: begin
                rd_en   = has_left;
                rd_addr = left_idx[ADDR_W-1:0];
            end
            bmhpq_pkg::S_DN_RDR: begin
                rd_en   = has_right;
                rd_addr = right_idx[ADDR_W-1:0];
            end
            bmhpq_pkg::S_DN_CMP: begin
                wr_en   = !dn_stop;
                wr_data = big_val;
            end
            bmhpq_pkg::S_UP_RD: begin
                rd_en   = pos_reg != '0;
                rd_addr = parent_idx;
            end
            bmhpq_pkg::S_UP_CMP: begin
                wr_en   = up_swap;
                wr_data = rd_key;
            end
            bmhpq_pkg::S_FINAL_WR: begin
                wr_en = 1'b1;
            end
            default: begin
            end
        endcase
        rsp_ld.load              = (state_reg == bmhpq_pkg::S_DONE) && out_free;
        rsp_ld.rsp.status        = status_reg;
        rsp_ld.rsp.result_key    = rkey_reg;
        rsp_ld.rsp.element_count = CNT_OW'(cnt_reg);
    end

    // Datapath register updates
    always_comb begin
        cnt_next      = cnt_reg;
        scan_idx_next = scan_idx_reg;
        chk_vld_next  = chk_vld_reg;
        chk_idx_next  = chk_idx_reg;
        pos_next      = pos_reg;
        moved_next    = moved_reg;
        has_r_next    = has_r_reg;
        mode_next     = mode_reg;
        key_next      = key_reg;
        mov_next      = mov_reg;
        lval_next     = lval_reg;
        rkey_next     = rkey_reg;
        status_next   = status_reg;
        case (state_reg)
            bmhpq_pkg::S_IDLE: begin
                if (accept) begin
                    mode_next     = s_req.mode;
                    key_next      = s_req.key;
                    mov_next      = s_req.key;
                    rkey_next     = s_req.key;
                    status_next   = bmhpq_pkg::STAT_OK;
                    scan_idx_next = '0;
                    chk_vld_next  = 1'b0;
                    case (s_req.mode)
                        bmhpq_pkg::MODE_INSERT: begin
                            if (is_full) begin
                                status_next = bmhpq_pkg::STAT_FULL;
                            end else begin
                                pos_next = cnt_reg[ADDR_W-1:0];
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        bmhpq_pkg::MODE_REMOVE: begin
                            if (is_empty) begin
                                status_next = bmhpq_pkg::STAT_EMPTY;
                            end
                        end
                        default: begin
                            if (is_empty) begin
                                status_next = bmhpq_pkg::STAT_EMPTY;
                                rkey_next   = '0;
                            end
                        end
                    endcase
                end
            end
            bmhpq_pkg::S_ROOT_WAIT: begin
                rkey_next = rd_key;
                pos_next  = '0;
            end
            bmhpq_pkg::S_SCAN: begin
                scan_idx_next = scan_idx_reg + CW'(1);
                chk_vld_next  = scan_more;
                chk_idx_next  = scan_idx_reg[ADDR_W-1:0];
                if (scan_hit) begin
                    pos_next = chk_idx_reg;
                end else if (!scan_more) begin
                    status_next = bmhpq_pkg::STAT_NOTFOUND;
                end
            end
            bmhpq_pkg::S_LAST_RD: begin
                cnt_next = cnt_m1;
            end
            bmhpq_pkg::S_LAST_WAIT: begin
                mov_next   = rd_key;
                moved_next = 1'b0;
            end
            bmhpq_pkg::S_DN_RDR: begin
                lval_next  = rd_key;
                has_r_next = has_right;
            end
            bmhpq_pkg::S_DN_CMP: begin
                if (!dn_stop) begin
                    pos_next   = big_idx;
                    moved_next = 1'b1;
                end
            end
            bmhpq_pkg::S_UP_CMP: begin
                if (up_swap) begin
                    pos_next = parent_idx;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bmhpq_pkg::S_IDLE;
            cnt_reg     <= '0;
            chk_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        chk_idx_reg  <= chk_idx_next;
        pos_reg      <= pos_next;
        moved_reg    <= moved_next;
        has_r_reg    <= has_r_next;
        mode_reg     <= mode_next;
        key_reg      <= key_next;
        mov_reg      <= mov_next;
        lval_reg     <= lval_next;
        rkey_reg     <= rkey_next;
        status_reg   <= status_next;
    end

endmodule

`default_nettype wire

// ===== design/bmhpq_out.sv =====
// Output register stage: holds a finished result until the receiver takes it.
`default_nettype none

module bmhpq_out (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire bmhpq_pkg::rsp_load_t rsp_ld,
    output logic                      out_free,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output bmhpq_pkg::rsp_t           m_rsp
);

    logic            valid_reg, valid_next;
    bmhpq_pkg::rsp_t rsp_reg;

    // Free once empty or being drained this cycle
    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_rsp    = rsp_reg;

    always_comb begin
        valid_next = valid_reg;
        if (rsp_ld.load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture the result on load
    always_ff @(posedge aclk) begin
        if (rsp_ld.load) begin
            rsp_reg <= rsp_ld.rsp;
        end
    end

endmodule

`default_nettype wire

// ===== design/bmhpq_checker.sv =====
// Port-level checks of the heap priority queue, bound to the top level.
`default_nettype none

module bmhpq_checker #(
    parameter int CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire bmhpq_pkg::rsp_t m_rsp
);

    localparam int CNT_OW = bmhpq_pkg::CNT_W;
    localparam logic [CNT_OW-1:0] FULL_CNT = CNT_OW'(CAPACITY);

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rsp))
        else $error("result changed or dropped while stalled");

    // Drop any result on reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A full status reports a full heap
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_rsp.status == bmhpq_pkg::STAT_FULL) |-> m_rsp.element_count == FULL_CNT)
        else $error("full status with count below capacity");

    // An empty status reports no elements
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_rsp.status == bmhpq_pkg::STAT_EMPTY) |-> m_rsp.element_count == '0)
        else $error("empty status with nonzero count");

    // A missed remove only happens on a nonempty heap
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_rsp.status == bmhpq_pkg::STAT_NOTFOUND) |-> m_rsp.element_count != '0)
        else $error("not-found status on an empty heap");

endmodule

bind binary_max_heap_priority_queue bmhpq_checker #(.CAPACITY(CAPACITY)) u_bmhpq_checker (.*);

`default_nettype wire

// ===== tb/sv/binary_max_heap_priority_queue_tb.sv =====
// Self-checking testbench for the bounded binary max-heap priority queue.
`default_nettype none

module binary_max_heap_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = bmhpq_pkg::CAPACITY_DEF;
    localparam int CNT_W       = bmhpq_pkg::CNT_W;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYC  = 40;

    logic            aclk    = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    bmhpq_pkg::req_t s_req   = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    bmhpq_pkg::rsp_t m_rsp;

    // Shadow heap and the results it predicts
    int              heap_model [CAPACITY];
    int              heap_fill = 0;
    bmhpq_pkg::rsp_t expected_rsp_q [$];

    int error_count = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    bit tx_idle_on  = 1'b1;
    int rx_left     = 0;
    int rx_style    = 0;

    binary_max_heap_priority_queue #(.CAPACITY(CAPACITY)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    always #4 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("binary_max_heap_priority_queue: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Heap predictor
    // ---------------------------------------------------------------
    function automatic void swap_slots(input int a, input int b);
        int t;
        t = heap_model[a];
        heap_model[a] = heap_model[b];
        heap_model[b] = t;
    endfunction

    function automatic void sift_up(input int start);
        int pos;
        int parent;
        pos = start;
        while (pos > 0 && pos < heap_fill) begin
            parent = (pos - 1) / 2;
            if (!(heap_model[parent] < heap_model[pos]))
                break;
            swap_slots(parent, pos);
            pos = parent;
        end
    endfunction

    function automatic void sift_down(input int start);
        int pos;
        int big;
        pos = start;
        while (pos < heap_fill) begin
            big = pos;
            if (2 * pos + 1 < heap_fill && heap_model[big] < heap_model[2 * pos + 1])
                big = 2 * pos + 1;
            if (2 * pos + 2 < heap_fill && heap_model[big] < heap_model[2 * pos + 2])
                big = 2 * pos + 2;
            if (big == pos)
                break;
            swap_slots(pos, big);
            pos = big;
        end
    endfunction

    // Move the last element into the hole and restore order both ways
    function automatic void take_out_slot(input int pos);
        heap_model[pos] = heap_model[heap_fill - 1];
        heap_fill--;
        if (pos < heap_fill) begin
            sift_down(pos);
            sift_up(pos);
        end
    endfunction

    // Apply one request to the shadow heap and return its result
    function automatic bmhpq_pkg::rsp_t heap_apply(input bmhpq_pkg::req_t r);
        bmhpq_pkg::rsp_t rsp;
        rsp.status     = bmhpq_pkg::STAT_OK;
        rsp.result_key = r.key;
        case (r.mode)
            bmhpq_pkg::MODE_INSERT: begin
                if (heap_fill >= CAPACITY) begin
                    rsp.status = bmhpq_pkg::STAT_FULL;
                end else begin
                    heap_model[heap_fill] = r.key;
                    heap_fill++;
                    sift_up(heap_fill - 1);
                end
            end
            bmhpq_pkg::MODE_POP: begin
                if (heap_fill == 0) begin
                    rsp.status     = bmhpq_pkg::STAT_EMPTY;
                    rsp.result_key = '0;
                end else begin
                    rsp.result_key = heap_model[0];
                    take_out_slot(0);
                end
            end
            bmhpq_pkg::MODE_REMOVE: begin
                if (heap_fill == 0) begin
                    rsp.status = bmhpq_pkg::STAT_EMPTY;
                end else begin
                    rsp.status = bmhpq_pkg::STAT_NOTFOUND;
                    for (int i = 0; i < heap_fill; i++) begin
                        if (heap_model[i] == r.key) begin
                            take_out_slot(i);
                            rsp.status = bmhpq_pkg::STAT_OK;
                            break;
                        end
                    end
                end
            end
            default: begin
                if (heap_fill == 0) begin
                    rsp.status     = bmhpq_pkg::STAT_EMPTY;
                    rsp.result_key = '0;
                end else begin
                    rsp.result_key = heap_model[0];
                end
            end
        endcase
        rsp.element_count = CNT_W'(heap_fill);
        return rsp;
    endfunction

    // ---------------------------------------------------------------
    // Result check and prediction on each accepted request
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        bmhpq_pkg::rsp_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $error("result with no request pending: status %0d key %0d count %0d",
                           m_rsp.status, m_rsp.result_key, m_rsp.element_count);
                    error_count++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (m_rsp.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_rsp.status);
                        error_count++;
                    end
                    if (m_rsp.result_key !== want.result_key) begin
                        $error("result_key: expected %0d, actual %0d",
                               want.result_key, m_rsp.result_key);
                        error_count++;
                    end
                    if (m_rsp.element_count !== want.element_count) begin
                        $error("element_count: expected %0d, actual %0d",
                               want.element_count, m_rsp.element_count);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_rsp_q = {expected_rsp_q, heap_apply(s_req)};
        end
    end

    // Stall the result channel on a pattern that changes style now and then
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_style = $urandom_range(0, 3);
            rx_left  = $urandom_range(10, 200);
        end
        rx_left--;
        case (rx_style)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ((rx_left % 8) < 5);
        endcase
    end

    // ---------------------------------------------------------------
    // Request driver: called and returns at a falling edge
    // ---------------------------------------------------------------
    task automatic send_request(input logic [bmhpq_pkg::MODE_W-1:0] mode, input int key);
        int              gap;
        bmhpq_pkg::req_t item;
        item.mode = mode;
        item.key  = key;
        // open a new burst, possibly after an idle gap
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = tx_idle_on ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_req   <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drop valid and hold until every pending result has come back
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(negedge aclk); while (expected_rsp_q.size() != 0);
    endtask

    function automatic int rand_key();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2, 3: return int'($urandom_range(0, 20)) - 10;
            default: return int'($urandom);
        endcase
    endfunction

    // Mostly a key that is held right now, so remove usually hits
    function automatic int held_or_random_key();
        if (heap_fill > 0 && $urandom_range(0, 4) != 0)
            return heap_model[$urandom_range(0, heap_fill - 1)];
        return rand_key();
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_empty_heap();
        send_request(bmhpq_pkg::MODE_PEEK, 32'h5a5a5a5a);
        send_request(bmhpq_pkg::MODE_POP, 32'ha5a5a5a5);
        send_request(bmhpq_pkg::MODE_REMOVE, 5);
    endtask

    task automatic test_extreme_keys();
        send_request(bmhpq_pkg::MODE_INSERT, 32'h7fffffff);
        send_request(bmhpq_pkg::MODE_INSERT, 32'h80000000);
        send_request(bmhpq_pkg::MODE_INSERT, 0);
        send_request(bmhpq_pkg::MODE_INSERT, -1);
        send_request(bmhpq_pkg::MODE_INSERT, 0);
        send_request(bmhpq_pkg::MODE_PEEK, 0);
        send_request(bmhpq_pkg::MODE_REMOVE, 123);
        send_request(bmhpq_pkg::MODE_REMOVE, 0);
        send_request(bmhpq_pkg::MODE_REMOVE, 32'h80000000);
        send_request(bmhpq_pkg::MODE_REMOVE, 32'h7fffffff);
        send_request(bmhpq_pkg::MODE_PEEK, -1);
        send_request(bmhpq_pkg::MODE_POP, 0);
        send_request(bmhpq_pkg::MODE_POP, 0);
        send_request(bmhpq_pkg::MODE_REMOVE, 0);
    endtask

    // Fill to capacity, push against the limit, then drain past empty
    task automatic test_full_heap();
        while (heap_fill < CAPACITY)
            send_request(bmhpq_pkg::MODE_INSERT, rand_key());
        send_request(bmhpq_pkg::MODE_INSERT, rand_key());
        send_request(bmhpq_pkg::MODE_PEEK, rand_key());
        send_request(bmhpq_pkg::MODE_REMOVE, heap_model[CAPACITY - 1]);
        send_request(bmhpq_pkg::MODE_INSERT, 32'h7fffffff);
        send_request(bmhpq_pkg::MODE_INSERT, 32'h80000000);
        while (heap_fill > 0)
            send_request(bmhpq_pkg::MODE_POP, int'($urandom));
        send_request(bmhpq_pkg::MODE_POP, int'($urandom));
        send_request(bmhpq_pkg::MODE_PEEK, int'($urandom));
    endtask

    // Phases that grow, hold or shrink the heap with random content
    task automatic test_random_traffic(input int n_items);
        int sent;
        int phase_len;
        int ins_pct;
        int pick;
        int rest;
        sent = 0;
        while (sent < n_items) begin
            phase_len  = $urandom_range(20, 80);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
                0: ins_pct = 70;
                1: ins_pct = 40;
                default: ins_pct = 15;
            endcase
            repeat (phase_len) begin
                pick = $urandom_range(0, 99);
                rest = (pick - ins_pct) * 100 / (100 - ins_pct);
                if (pick < ins_pct)
                    send_request(bmhpq_pkg::MODE_INSERT, rand_key());
                else if (rest < 40)
                    send_request(bmhpq_pkg::MODE_POP, int'($urandom));
                else if (rest < 75)
                    send_request(bmhpq_pkg::MODE_REMOVE, held_or_random_key());
                else
                    send_request(bmhpq_pkg::MODE_PEEK, int'($urandom));
                sent++;
            end
        end
        tx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_heap();
        test_extreme_keys();
        test_full_heap();
        test_random_traffic(480);
        wait_for_drain();
        test_random_traffic(480);

        // drain and let the block settle
        wait_for_drain();
        repeat (SETTLE_CYC) @(negedge aclk);
        if (error_count == 0 && expected_rsp_q.size() == 0) begin
            $display("binary_max_heap_priority_queue: match");
        end else begin
            $display("binary_max_heap_priority_queue: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
